// File: rtl/ctc_pkg.sv
// ----------------------------------------------------------------------------
// ctc_pkg
// Types, codes and reset values shared by the countdown timer controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ctc_pkg;

    localparam int ADDR_W       = 5;
    localparam int DATA_W       = 32;
    localparam int S_TDATA_W    = 24;
    localparam int M_TDATA_W    = 40;

    localparam logic [7:0] LEFT_X_RST      = 8'd186;
    localparam logic [7:0] RIGHT_X_RST     = 8'd224;
    localparam logic [7:0] STOP_TOP_RST    = 8'd34;
    localparam logic [7:0] PLAY_TOP_RST    = 8'd76;
    localparam logic [7:0] PAUSE_TOP_RST   = 8'd118;
    localparam logic [7:0] BTN_HEIGHT_RST  = 8'd38;

    localparam logic [5:0] STEP_SECONDS = 6'd30;
    localparam logic [5:0] MAX_MINUTE   = 6'd59;
    localparam logic [5:0] MAX_SECOND   = 6'd59;
    localparam logic [9:0] MAX_MILLI    = 10'd999;

    typedef enum logic [2:0] {
        REG_LEFT_X     = 3'd0,
        REG_RIGHT_X    = 3'd1,
        REG_STOP_TOP   = 3'd2,
        REG_PLAY_TOP   = 3'd3,
        REG_PAUSE_TOP  = 3'd4,
        REG_BTN_HEIGHT = 3'd5
    } reg_idx_t;

    typedef enum logic {
        CMD_TICK  = 1'b0,
        CMD_FRAME = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        RUN_STOP  = 2'd0,
        RUN_PLAY  = 2'd1,
        RUN_PAUSE = 2'd2
    } run_mode_t;

    typedef enum logic [1:0] {
        COLOUR_STOP    = 2'd0,
        COLOUR_PLAY    = 2'd1,
        COLOUR_PAUSE   = 2'd2,
        COLOUR_EXPIRED = 2'd3
    } colour_t;

    typedef struct packed {
        logic [7:0] left_x;
        logic [7:0] right_x;
        logic [7:0] stop_top;
        logic [7:0] play_top;
        logic [7:0] pause_top;
        logic [7:0] height;
    } ctc_cfg_t;

    typedef struct packed {
        cmd_t       cmd;
        logic       key_up;
        logic       key_dn;
        logic [7:0] touch_x;
        logic [7:0] touch_y;
    } ctc_item_t;

    typedef struct packed {
        logic [5:0]  minutes;
        logic [5:0]  seconds;
        logic [9:0]  millis;
        logic [11:0] preset;
        run_mode_t   run;
        logic        tick_en;
        colour_t     colour;
    } ctc_state_t;

endpackage

// File: rtl/ctc_apb_regs.sv
// ----------------------------------------------------------------------------
// ctc_apb_regs
// APB register file holding the touch button geometry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctc_apb_regs
    import ctc_pkg::*;
#(
    parameter int AW = ADDR_W
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [AW-1:0]  paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready,
    output ctc_cfg_t       cfg
);

    ctc_cfg_t cfg_reg, cfg_next;
    logic     wr_en;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = reg_idx_t'(paddr[4:2]);
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                REG_LEFT_X:     cfg_next.left_x    = pwdata[7:0];
                REG_RIGHT_X:    cfg_next.right_x   = pwdata[7:0];
                REG_STOP_TOP:   cfg_next.stop_top  = pwdata[7:0];
                REG_PLAY_TOP:   cfg_next.play_top  = pwdata[7:0];
                REG_PAUSE_TOP:  cfg_next.pause_top = pwdata[7:0];
                REG_BTN_HEIGHT: cfg_next.height    = pwdata[7:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_LEFT_X:     prdata = {24'd0, cfg_reg.left_x};
            REG_RIGHT_X:    prdata = {24'd0, cfg_reg.right_x};
            REG_STOP_TOP:   prdata = {24'd0, cfg_reg.stop_top};
            REG_PLAY_TOP:   prdata = {24'd0, cfg_reg.play_top};
            REG_PAUSE_TOP:  prdata = {24'd0, cfg_reg.pause_top};
            REG_BTN_HEIGHT: prdata = {24'd0, cfg_reg.height};
            default:        prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.left_x    <= LEFT_X_RST;
            cfg_reg.right_x   <= RIGHT_X_RST;
            cfg_reg.stop_top  <= STOP_TOP_RST;
            cfg_reg.play_top  <= PLAY_TOP_RST;
            cfg_reg.pause_top <= PAUSE_TOP_RST;
            cfg_reg.height    <= BTN_HEIGHT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: rtl/ctc_step.sv
// ----------------------------------------------------------------------------
// ctc_step
// Next-state logic for one item: millisecond countdown, preset keys, touch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctc_step
    import ctc_pkg::*;
(
    input  ctc_cfg_t   cfg,
    input  ctc_state_t cur,
    input  ctc_item_t  item,
    output ctc_state_t nxt,
    output logic       expired
);

    // returns {minutes, seconds}
    function automatic logic [11:0] key_up_fn(input logic [5:0] m, input logic [5:0] s);
        logic [11:0] r;
        r = {m, s};
        if (!(m >= MAX_MINUTE && s >= STEP_SECONDS)) begin
            if (s >= STEP_SECONDS) begin
                r = {m + 6'd1, s - STEP_SECONDS};
            end else begin
                r = {m, s + STEP_SECONDS};
            end
        end
        return r;
    endfunction

    function automatic logic [11:0] key_dn_fn(input logic [5:0] m, input logic [5:0] s);
        logic [11:0] r;
        if (s >= STEP_SECONDS) begin
            r = {m, s - STEP_SECONDS};
        end else if (m != 6'd0) begin
            r = {m - 6'd1, s + STEP_SECONDS};
        end else begin
            r = {m, 6'd0};
        end
        return r;
    endfunction

    function automatic logic hit(input ctc_cfg_t c, input logic [7:0] x,
                                 input logic [7:0] y, input logic [7:0] top);
        logic [8:0] bottom;
        bottom = {1'b0, top} + {1'b0, c.height};
        return (x >= c.left_x) && (x <= c.right_x) && (y >= top) &&
               ({1'b0, y} <= bottom);
    endfunction

    logic [11:0] after_up;
    logic [11:0] after_down;
    logic [11:0] sixty_m;
    logic        touched;
    logic        keys_on;

    assign after_up   = item.key_up ? key_up_fn(cur.minutes, cur.seconds)
                                    : {cur.minutes, cur.seconds};
    assign after_down = item.key_dn ? key_dn_fn(after_up[11:6], after_up[5:0])
                                    : after_up;
    // 60*m = 64*m - 4*m
    assign sixty_m    = {after_down[11:6], 6'd0} - {4'd0, after_down[11:6], 2'd0};
    assign touched    = (item.touch_x != 8'd0) || (item.touch_y != 8'd0);
    assign keys_on    = (cur.run == RUN_STOP) && (item.key_up || item.key_dn);

    always_comb begin
        nxt     = cur;
        expired = 1'b0;
        if (item.cmd == CMD_TICK) begin
            if (cur.tick_en) begin
                if (cur.millis != 10'd0 || cur.seconds != 6'd0 || cur.minutes != 6'd0) begin
                    if (cur.millis == 10'd0) begin
                        nxt.millis = MAX_MILLI;
                        if (cur.seconds == 6'd0) begin
                            nxt.seconds = MAX_SECOND;
                            nxt.minutes = cur.minutes - 6'd1;
                        end else begin
                            nxt.seconds = cur.seconds - 6'd1;
                        end
                    end else begin
                        nxt.millis = cur.millis - 10'd1;
                    end
                end else begin
                    expired     = 1'b1;
                    nxt.colour  = COLOUR_EXPIRED;
                    nxt.tick_en = 1'b0;
                end
            end
        end else begin
            if (keys_on) begin
                nxt.minutes = after_down[11:6];
                nxt.seconds = after_down[5:0];
                nxt.preset  = sixty_m + {6'd0, after_down[5:0]};
            end
            // later regions override earlier ones
            if (touched && hit(cfg, item.touch_x, item.touch_y, cfg.stop_top)) begin
                nxt.tick_en = 1'b0;
                nxt.minutes = 6'd0;
                nxt.seconds = 6'd0;
                nxt.millis  = 10'd0;
                nxt.run     = RUN_STOP;
                nxt.colour  = COLOUR_STOP;
            end
            if (touched && hit(cfg, item.touch_x, item.touch_y, cfg.play_top)) begin
                nxt.tick_en = 1'b1;
                nxt.run     = RUN_PLAY;
                nxt.colour  = COLOUR_PLAY;
            end
            if (touched && hit(cfg, item.touch_x, item.touch_y, cfg.pause_top)) begin
                nxt.tick_en = 1'b0;
                nxt.run     = RUN_PAUSE;
                nxt.colour  = COLOUR_PAUSE;
            end
        end
    end

endmodule

// File: rtl/countdown_timer_controller.sv
// An accepted item is held in the input register; its result is then registered behind m_tvalid.
// Throughput: one item per cycle unless m_ stalls; state_reg updates once per item.
// Input and result registers part the two streams, so stalls on m_ side do not lose items.
// Reset (aresetn low, synchronous): count, preset, run state, tick enable and colour
// clear to zero/stop, both stages empty, button geometry back to its defaults.
// ----------------------------------------------------------------------------
// countdown_timer_controller
// Millisecond countdown timer with preset keys and touch buttons.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module countdown_timer_controller
    import ctc_pkg::*;
#(
    parameter int AW = ADDR_W
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // APB
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [AW-1:0]         paddr,
    input  logic [DATA_W-1:0]     pwdata,
    output logic [DATA_W-1:0]     prdata,
    output logic                  pready,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // key_up[0], key_dn[1], touch_x[9:2], touch_y[17:10], zero pad
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // cmd[0]
    input  logic                  s_tuser,
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // minutes[5:0], seconds[11:6], millis[21:12], preset_seconds[33:22],
    // run_mode[35:34], colour_mode[37:36], expired[38], zero pad
    output logic [M_TDATA_W-1:0]  m_tdata
);

    ctc_cfg_t   cfg;
    ctc_state_t state_reg, state_next;
    ctc_item_t  item_reg;
    logic       in_valid_reg;
    logic       out_valid_reg;
    logic       out_ready;
    logic       consume;
    logic       step_expired;
    logic [M_TDATA_W-1:0] out_data_reg, out_data_next;

    ctc_apb_regs #(
        .AW (AW)
    ) u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ctc_step u_step (
        .cfg     (cfg),
        .cur     (state_reg),
        .item    (item_reg),
        .nxt     (state_next),
        .expired (step_expired)
    );

    assign out_ready = !out_valid_reg || m_tready;
    assign consume   = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || out_ready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    assign out_data_next = {1'b0, step_expired, state_next.colour, state_next.run,
                            state_next.preset, state_next.millis, state_next.seconds,
                            state_next.minutes};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{minutes: 6'd0, seconds: 6'd0, millis: 10'd0,
                               preset: 12'd0, run: RUN_STOP, tick_en: 1'b0,
                               colour: COLOUR_STOP};
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_ready) begin
                out_valid_reg <= in_valid_reg;
            end
            if (consume) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= '{cmd: cmd_t'(s_tuser), key_up: s_tdata[0], key_dn: s_tdata[1],
                          touch_x: s_tdata[9:2], touch_y: s_tdata[17:10]};
        end
        if (consume) begin
            out_data_reg <= out_data_next;
        end
    end

    a_expired_colour: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[38] |-> m_tdata[37:36] == COLOUR_EXPIRED)
        else $error("expired result without expired colour");

    a_frame_no_expiry: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && item_reg.cmd == CMD_FRAME |-> !step_expired)
        else $error("frame item flagged expiry");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.minutes <= MAX_MINUTE && state_reg.seconds <= MAX_SECOND &&
        state_reg.millis <= MAX_MILLI)
        else $error("count out of range");

    a_state_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !consume |=> $stable(state_reg))
        else $error("state changed without an item");

endmodule
